FILE: sv/itp_pkg.sv
// Shared types, constants and character helpers for the infix-to-postfix converter.
`default_nettype none
package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic       KIND_CHAR  = 1'b0;
    localparam logic       KIND_FLUSH = 1'b1;

    localparam logic [1:0] PRI_LOW  = 2'd0;
    localparam logic [1:0] PRI_ADD  = 2'd1;
    localparam logic [1:0] PRI_MUL  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_WORK
    } state_t;

    // shift control shared by every stack cell
    typedef struct packed {
        logic push;
        logic pop;
    } shift_ctrl_t;

    function automatic logic [1:0] op_pri(input logic [7:0] ch);
        logic [1:0] p;
        case (ch) inside
            CH_MUL, CH_DIV: p = PRI_MUL;
            CH_ADD, CH_SUB: p = PRI_ADD;
            default:        p = PRI_LOW;
        endcase
        return p;
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return ch inside {[CH_ZERO:CH_NINE]};
    endfunction

endpackage
`default_nettype wire

FILE: sv/itp_cell.sv
// One entry of the shifting operator stack; cell 0 holds the top.
`default_nettype none
module itp_cell (
    input  wire logic                clk,
    input  wire itp_pkg::shift_ctrl_t ctrl,
    input  wire logic [7:0]          from_above,
    input  wire logic [7:0]          from_below,
    output logic [7:0]               data
);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        if (ctrl.pop)
        begin
            data_next = from_below;
        end
        else if (ctrl.push)
        begin
            data_next = from_above;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
`default_nettype wire

FILE: sv/infix_to_postfix_converter.sv
// Top level: sequencer, output register and the chain of stack cells.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------
//  item     | item_valid / item_ready    | kind, in_char
//  result   | result_valid / result_ready| out_char, last_of_run, expr_done
//
// An item is taken while idle, then each later step in the work state either
// emits one popped word or finishes the item.
// The stack is a row of shifting cells that all move together on a push or pop.
// Reset empties the stack count and the output valid flag; no clearing pass.
// A stalled result holds the sequencer; a new item may be taken while the
// last word of the previous one still waits.
`default_nettype none
module infix_to_postfix_converter (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_ready,
    input  wire logic       kind,
    input  wire logic [7:0] in_char,
    output logic            result_valid,
    input  wire logic       result_ready,
    output logic [7:0]      out_char,
    output logic            last_of_run,
    output logic            expr_done
);

    localparam int DEPTH = itp_pkg::STACK_DEPTH;
    localparam int CW    = itp_pkg::CNT_W;

    itp_pkg::state_t      state_reg, state_next;
    logic                 kind_reg;
    logic [7:0]           ch_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_char_reg, out_char_next;
    logic                 last_reg, last_next;
    logic                 done_reg, done_next;

    logic [7:0]           cell_data [DEPTH];
    itp_pkg::shift_ctrl_t ctrl;

    logic                 accept;
    logic                 out_free;
    logic                 cont_top, cont_nxt;
    logic                 empty, full, has_two;
    logic                 emit, finish, step_go;
    logic                 want_push, want_pop;
    logic [7:0]           emit_char;
    logic                 emit_last, emit_done;

    function automatic logic pop_cond(input logic k, input logic [7:0] c,
                                      input logic [7:0] x);
        logic r;
        if (k == itp_pkg::KIND_FLUSH)
        begin
            r = 1'b1;
        end
        else if (c == itp_pkg::CH_CLOSE)
        begin
            r = (x != itp_pkg::CH_OPEN);
        end
        else
        begin
            r = (x != itp_pkg::CH_OPEN) && (itp_pkg::op_pri(x) >= itp_pkg::op_pri(c));
        end
        return r;
    endfunction

    assign item_ready = (state_reg == itp_pkg::ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign out_free   = !out_valid_reg || result_ready;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign has_two  = (count_reg > CW'(1));
    assign cont_top = !empty && pop_cond(kind_reg, ch_reg, cell_data[0]);
    assign cont_nxt = has_two && pop_cond(kind_reg, ch_reg, cell_data[1]);

    // one step of the current item
    always_comb
    begin
        emit      = 1'b0;
        finish    = 1'b0;
        want_push = 1'b0;
        want_pop  = 1'b0;
        emit_char = cell_data[0];
        emit_last = 1'b0;
        emit_done = 1'b0;
        if (state_reg == itp_pkg::ST_WORK)
        begin
            if (kind_reg == itp_pkg::KIND_FLUSH)
            begin
                if (cont_top)
                begin
                    emit     = 1'b1;
                    want_pop = 1'b1;
                end
                else
                begin
                    emit      = 1'b1;
                    emit_char = itp_pkg::CH_NUL;
                    emit_last = 1'b1;
                    emit_done = 1'b1;
                    finish    = 1'b1;
                end
            end
            else if (itp_pkg::is_digit(ch_reg))
            begin
                emit      = 1'b1;
                emit_char = ch_reg;
                emit_last = 1'b1;
                finish    = 1'b1;
            end
            else if (ch_reg == itp_pkg::CH_OPEN)
            begin
                want_push = !full;
                finish    = 1'b1;
            end
            else if (cont_top)
            begin
                emit      = 1'b1;
                want_pop  = 1'b1;
                emit_last = !cont_nxt;
            end
            else if (ch_reg == itp_pkg::CH_CLOSE)
            begin
                want_pop = !empty;
                finish   = 1'b1;
            end
            else
            begin
                want_push = !full;
                finish    = 1'b1;
            end
        end
    end

    assign step_go = !emit || out_free;
    assign ctrl    = '{push: want_push && step_go, pop: want_pop && step_go};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            itp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = itp_pkg::ST_WORK;
                end
            end
            itp_pkg::ST_WORK:
            begin
                if (finish && step_go)
                begin
                    state_next = itp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = itp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.pop)
        begin
            count_next = count_reg - CW'(1);
        end
        else if (ctrl.push)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit && out_free)
        begin
            out_valid_next = 1'b1;
            out_char_next  = emit_char;
            last_next      = emit_last;
            done_next      = emit_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= itp_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            ch_reg   <= in_char;
        end
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
        done_reg     <= done_next;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [7:0] above;
        logic [7:0] below;
        if (i == 0)
        begin : g_top
            assign above = ch_reg;
        end
        else
        begin : g_mid
            assign above = cell_data[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_bot
            assign below = itp_pkg::CH_NUL;
        end
        else
        begin : g_up
            assign below = cell_data[i+1];
        end
        itp_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .from_above (above),
            .from_below (below),
            .data       (cell_data[i])
        );
    end

    assign result_valid = out_valid_reg;
    assign out_char     = out_char_reg;
    assign last_of_run  = last_reg;
    assign expr_done    = done_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("stack count beyond depth");

    a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.push && ctrl.pop))
        else $error("push and pop in one cycle");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> count_reg != '0)
        else $error("pop from empty stack");

    a_term_word: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && expr_done) |-> (last_of_run && out_char == itp_pkg::CH_NUL))
        else $error("terminator word malformed");

    a_emit_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itp_pkg::ST_WORK && emit && !out_free)
        |=> state_reg == itp_pkg::ST_WORK)
        else $error("sequencer moved on under a stalled word");
`endif

endmodule
`default_nettype wire
